// ===== design/cdo_pkg.sv =====
// ----------------------------------------------------------------------------
// cdo_pkg: shared types and constants for the calendar date offset core
// Holds the sequencer states, control and status bundles, calendar constants
// and the month length function.
// ----------------------------------------------------------------------------
package cdo_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int OFFSET_W = 16;
    localparam int ACC_W    = 18;
    localparam int CYC_W    = 9;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [YEAR_W-1:0]  CYCLE_LEN  = 14'd400;
    localparam logic [CYC_W-1:0]   CYCLE_LAST = 9'd399;
    localparam logic [CYC_W-1:0]   CENTURY_1  = 9'd100;
    localparam logic [CYC_W-1:0]   CENTURY_2  = 9'd200;
    localparam logic [CYC_W-1:0]   CENTURY_3  = 9'd300;
    localparam logic [MONTH_W-1:0] JANUARY    = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY   = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER   = 4'd12;
    localparam logic [DAY_W-1:0]   DECEMBER_DAYS = 5'd31;

    localparam logic KIND_ADVANCE = 1'b0;
    localparam logic KIND_RETREAT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic prep_step;
        logic walk_step;
    } ctl_t;

    typedef struct packed {
        logic prep_done;
        logic walk_done;
    } status_t;

    function automatic logic [DAY_W-1:0] month_days(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] days;
        if (month == FEBRUARY) begin
            days = leap ? 5'd29 : 5'd28;
        end
        else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            days = 5'd30;
        end
        else begin
            days = 5'd31;
        end
        return days;
    endfunction

endpackage

// ===== design/cdo_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdo_ctrl: sequencer for the calendar date offset core
// Steps through load, year cycle reduction, the month walk and result hand-off.
// ----------------------------------------------------------------------------
module cdo_ctrl
    import cdo_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    out_busy,
    input  status_t status,
    output logic    in_ready,
    output logic    out_load,
    output ctl_t    ctl
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (status.prep_done) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (status.walk_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        out_load      = 1'b0;
        ctl.load      = 1'b0;
        ctl.prep_step = 1'b0;
        ctl.walk_step = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            ST_PREP:
            begin
                ctl.prep_step = !status.prep_done;
            end
            ST_WALK:
            begin
                ctl.walk_step = !status.walk_done;
            end
            ST_FINISH:
            begin
                out_load = !out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/cdo_datapath.sv =====
// ----------------------------------------------------------------------------
// cdo_datapath: date registers and shared adder for the calendar date offset
// One signed adder forms the initial day count, reduces the year modulo the
// leap cycle and moves the day count by one month length per step.
// ----------------------------------------------------------------------------
module cdo_datapath
    import cdo_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_t                ctl,
    input  logic                kind,
    input  logic [DAY_W-1:0]    start_day,
    input  logic [MONTH_W-1:0]  start_month,
    input  logic [YEAR_W-1:0]   start_year,
    input  logic [OFFSET_W-1:0] offset_days,
    output status_t             status,
    output logic [DAY_W-1:0]    res_day,
    output logic [MONTH_W-1:0]  res_month,
    output logic [YEAR_W-1:0]   res_year,
    output logic                res_error
);

    logic signed [ACC_W-1:0] day_reg,   day_next;
    logic [MONTH_W-1:0]      month_reg, month_next;
    logic [YEAR_W-1:0]       year_reg,  year_next;
    logic [YEAR_W-1:0]       cyc_reg,   cyc_next;
    logic [DAY_W-1:0]        sday_reg;
    logic [MONTH_W-1:0]      smonth_reg;
    logic [YEAR_W-1:0]       syear_reg;

    logic signed [ACC_W-1:0] add_a, add_b, add_sum;
    logic                    add_sub;

    logic [CYC_W-1:0]   cyc;
    logic               leap;
    logic [DAY_W-1:0]   dim, dim_prev;
    logic               fwd_need, back_need, fwd_err, back_err, range_bad, err;
    logic [MONTH_W-1:0] month_clamped;

    assign cyc  = cyc_reg[CYC_W-1:0];
    assign leap = (year_reg[1:0] == 2'b00) && (cyc != CENTURY_1)
                  && (cyc != CENTURY_2) && (cyc != CENTURY_3);
    assign dim      = month_days(month_reg, leap);
    assign dim_prev = (month_reg == JANUARY) ? DECEMBER_DAYS
                      : month_days(month_reg - 4'd1, leap);

    assign fwd_need  = day_reg > $signed({{(ACC_W-DAY_W){1'b0}}, dim});
    assign back_need = day_reg < $signed(18'sd1);
    assign fwd_err   = fwd_need && (month_reg == DECEMBER) && (year_reg >= YEAR_MAX);
    assign back_err  = !fwd_need && back_need && (month_reg == JANUARY)
                       && (year_reg <= YEAR_MIN);
    assign range_bad = (year_reg == '0) || (year_reg > YEAR_MAX);
    assign err       = fwd_err || back_err || range_bad;

    assign status.prep_done = cyc_reg < CYCLE_LEN;
    assign status.walk_done = !(fwd_need || back_need) || fwd_err || back_err;

    always_comb
    begin
        if (ctl.load) begin
            add_a   = $signed({{(ACC_W-DAY_W){1'b0}}, start_day});
            add_b   = $signed({{(ACC_W-OFFSET_W){1'b0}}, offset_days});
            add_sub = (kind == KIND_RETREAT);
        end
        else if (ctl.prep_step) begin
            add_a   = $signed({{(ACC_W-YEAR_W){1'b0}}, cyc_reg});
            add_b   = $signed({{(ACC_W-YEAR_W){1'b0}}, CYCLE_LEN});
            add_sub = 1'b1;
        end
        else begin
            add_a   = day_reg;
            add_b   = $signed({{(ACC_W-DAY_W){1'b0}}, fwd_need ? dim : dim_prev});
            add_sub = fwd_need;
        end
        add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
    end

    always_comb
    begin
        if (start_month == '0) begin
            month_clamped = JANUARY;
        end
        else if (start_month > DECEMBER) begin
            month_clamped = DECEMBER;
        end
        else begin
            month_clamped = start_month;
        end
    end

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        cyc_next   = cyc_reg;
        if (ctl.load) begin
            day_next   = add_sum;
            month_next = month_clamped;
            year_next  = start_year;
            cyc_next   = start_year;
        end
        else if (ctl.prep_step) begin
            cyc_next = add_sum[YEAR_W-1:0];
        end
        else if (ctl.walk_step) begin
            day_next = add_sum;
            if (fwd_need) begin
                if (month_reg == DECEMBER) begin
                    month_next = JANUARY;
                    year_next  = year_reg + 14'd1;
                    cyc_next   = (cyc == CYCLE_LAST) ? '0
                                 : {{(YEAR_W-CYC_W){1'b0}}, cyc + 9'd1};
                end
                else begin
                    month_next = month_reg + 4'd1;
                end
            end
            else begin
                if (month_reg == JANUARY) begin
                    month_next = DECEMBER;
                    year_next  = year_reg - 14'd1;
                    cyc_next   = (cyc == '0) ? {{(YEAR_W-CYC_W){1'b0}}, CYCLE_LAST}
                                 : {{(YEAR_W-CYC_W){1'b0}}, cyc - 9'd1};
                end
                else begin
                    month_next = month_reg - 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        cyc_reg   <= cyc_next;
        if (ctl.load) begin
            sday_reg   <= start_day;
            smonth_reg <= start_month;
            syear_reg  <= start_year;
        end
    end

    assign res_error = err;
    assign res_day   = err ? sday_reg   : day_reg[DAY_W-1:0];
    assign res_month = err ? smonth_reg : month_reg;
    assign res_year  = err ? syear_reg  : year_reg;

    a_month_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.walk_step |-> (month_reg >= JANUARY) && (month_reg <= DECEMBER))
        else $error("month left 1..12 during the walk");

    a_cycle_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.walk_step |-> cyc_reg < CYCLE_LEN)
        else $error("year cycle position not reduced before the walk");

    a_forward_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.walk_step && fwd_need) |=> day_reg >= $signed(18'sd1))
        else $error("forward step left a day count below one");

endmodule

// ===== design/calendar_date_offset_core.sv =====
// ----------------------------------------------------------------------------
// calendar_date_offset_core: Gregorian date plus or minus a day count
// Moves a date forward or back by up to 65535 days, one month per cycle.
//
// Usage: an item (kind, start date, offset) is taken on the input channel
// when in_valid and in_ready are both high. in_ready is high only while the
// core is idle. The item is loaded, the start year is reduced modulo 400 by
// repeated subtraction, then the date walks one month per cycle through a
// single shared adder until the day count lies within its month.
// One item is in work at a time. The result sits in an output register; the
// core accepts a new item while it waits, and a finished walk holds until the
// register is free. If the result year leaves 1..9999, range_error is set and
// the start date echoed.
// Reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module calendar_date_offset_core
    import cdo_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [DAY_W-1:0]    start_day,
    input  logic [MONTH_W-1:0]  start_month,
    input  logic [YEAR_W-1:0]   start_year,
    input  logic [OFFSET_W-1:0] offset_days,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [DAY_W-1:0]    result_day,
    output logic [MONTH_W-1:0]  result_month,
    output logic [YEAR_W-1:0]   result_year,
    output logic                range_error
);

    ctl_t               ctl;
    status_t            status;
    logic               out_load;
    logic               out_busy;
    logic               out_valid_reg, out_valid_next;
    logic [DAY_W-1:0]   res_day,   day_reg;
    logic [MONTH_W-1:0] res_month, month_reg;
    logic [YEAR_W-1:0]  res_year,  year_reg;
    logic               res_error, error_reg;

    assign out_busy = out_valid_reg && !out_ready;

    cdo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (out_busy),
        .status   (status),
        .in_ready (in_ready),
        .out_load (out_load),
        .ctl      (ctl)
    );

    cdo_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .kind        (kind),
        .start_day   (start_day),
        .start_month (start_month),
        .start_year  (start_year),
        .offset_days (offset_days),
        .status      (status),
        .res_day     (res_day),
        .res_month   (res_month),
        .res_year    (res_year),
        .res_error   (res_error)
    );

    always_comb
    begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load) begin
            day_reg   <= res_day;
            month_reg <= res_month;
            year_reg  <= res_year;
            error_reg <= res_error;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_day   = day_reg;
    assign result_month = month_reg;
    assign result_year  = year_reg;
    assign range_error  = error_reg;

endmodule
